// File: sv/atma_pkg.sv
// Shared types and constants of the ADC temperature moving-average unit.
package atma_pkg;

  localparam int CodeW     = 12;
  localparam int SampleW   = 19;
  localparam int QuotW     = 19;
  localparam int CelsiusW  = 19;
  localparam int FahrW     = 20;
  localparam int ThrW      = 9;
  localparam int Div5MulW  = 20;
  localparam int Div5Shift = 22;
  localparam int FahrXW    = 22;

  // Samples are kept as code*75, i.e. Celsius Q8 plus SampleBias.
  localparam int SampleBias = 71424;

  localparam logic [6:0]                   CodeGain    = 7'd75;
  localparam logic [SampleW-1:0]           SampleReset = 19'd71424;
  localparam logic signed [ThrW-1:0]       ThrReset    = 9'sd40;
  localparam logic [Div5MulW-1:0]          Div5Mul     = 20'd838861;
  localparam logic [FahrXW-1:0]            FahrRound   = 22'd4;
  localparam logic signed [FahrW:0]        FahrOffset  = 21'sd120372;
  localparam logic signed [CelsiusW:0]     CelsOffset  = 20'sd71424;

  typedef logic [SampleW-1:0] sample_t;

  typedef struct packed {
    logic signed [CelsiusW-1:0] mean_c;
    logic signed [FahrW-1:0]    mean_f;
    logic                       over;
  } result_t;

  typedef struct packed {
    logic busy;
    logic last_valid;
  } stat_t;

endpackage

// File: sv/atma_in_if.sv
// Request channel carrying one ADC code.
interface atma_in_if;
  import atma_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

// File: sv/atma_out_if.sv
// Result channel carrying the filtered temperature.
interface atma_out_if;
  import atma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [CelsiusW-1:0] mean_celsius_q8;
  logic signed [FahrW-1:0]    mean_fahrenheit_q8;
  logic                       over_threshold;

  modport source (output valid, output mean_celsius_q8, output mean_fahrenheit_q8,
                  output over_threshold, input ready);
  modport sink (input valid, input mean_celsius_q8, input mean_fahrenheit_q8,
                input over_threshold, output ready);
endinterface

// File: sv/adc_temperature_moving_average_unit.sv
// Top level: ADC temperature moving-average unit.
// Each accepted ADC code enters a chain of TAPS cells (cleared to 0 C at reset) and updates a
// running sum; via the sum, product and quotient registers the output register gets the result:
// the floor mean in Celsius Q8, the same mean in Fahrenheit Q8 and the over-threshold flag.
// One code is in flight at a time: the sum update, the reciprocal multiply for the divide by
// TAPS, the quotient correction and the Fahrenheit scaling run as four steps, and a new code is
// accepted in the cycle the previous one leaves the last step. A result that is not taken holds
// the last step and input is stalled. The threshold register must be written only while idle.
module adc_temperature_moving_average_unit #(
  parameter int TAPS = 50
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic signed [atma_pkg::ThrW-1:0] cfg_wdata_i,
  atma_in_if.sink                          req_i,
  atma_out_if.source                       res_o
);
  import atma_pkg::*;

  localparam int SumW = SampleW + $clog2(TAPS);
  localparam logic [SumW-1:0] SumReset = SumW'(TAPS * SampleBias);

  sample_t chain [TAPS];
  sample_t new_sample;
  sample_t tail_q;
  logic [SumW-1:0] sum_q;
  logic signed [ThrW-1:0] thr_q;
  logic v1_q;
  logic acc;
  logic out_free;
  logic out_valid_q;
  result_t out_res_q;
  result_t res;
  stat_t stat;

  assign new_sample = SampleW'(req_i.adc_code) * SampleW'(CodeGain);
  assign out_free   = ~out_valid_q | res_o.ready;
  assign req_i.ready = ~v1_q & ~stat.busy & (~stat.last_valid | out_free);
  assign acc        = req_i.valid & req_i.ready;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      atma_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (acc),
        .d_i     (new_sample),
        .q_o     (chain[i])
      );
    end else begin : g_body
      atma_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (acc),
        .d_i     (chain[i-1]),
        .q_o     (chain[i])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      tail_q <= chain[TAPS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= SumReset;
      thr_q <= ThrReset;
      v1_q  <= 1'b0;
    end else begin
      v1_q <= acc;
      if (v1_q) begin
        sum_q <= sum_q + SumW'(chain[0]) - SumW'(tail_q);
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  atma_scaler #(.TAPS(TAPS)) u_scaler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (v1_q),
    .sum_i   (sum_q),
    .thr_i   (thr_q),
    .take_i  (out_free),
    .stat_o  (stat),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.last_valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.last_valid && out_free) begin
      out_res_q <= res;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.mean_celsius_q8    = out_res_q.mean_c;
  assign res_o.mean_fahrenheit_q8 = out_res_q.mean_f;
  assign res_o.over_threshold     = out_res_q.over;

  a_single_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({v1_q, stat.busy, stat.last_valid}))
    else $error("overlapping items in flight");

  a_thr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(thr_q))
    else $error("threshold changed without write");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready && stat.last_valid |=> stat.last_valid)
    else $error("stalled result dropped");

endmodule

// File: sv/atma_cell.sv
// One tap of the sample delay line.
module atma_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  atma_pkg::sample_t d_i,
  output atma_pkg::sample_t q_o
);
  import atma_pkg::*;

  sample_t q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= SampleReset;
    end else if (shift_i) begin
      q_q <= d_i;
    end
  end

  assign q_o = q_q;

endmodule

// File: sv/atma_scaler.sv
// Divide-by-taps, Celsius/Fahrenheit scaling and threshold compare pipeline.
module atma_scaler #(
  parameter int TAPS = 50
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 start_i,
  input  logic [atma_pkg::SampleW+$clog2(TAPS)-1:0]            sum_i,
  input  logic signed [atma_pkg::ThrW-1:0]                     thr_i,
  input  logic                                                 take_i,
  output atma_pkg::stat_t                                      stat_o,
  output atma_pkg::result_t                                    res_o
);
  import atma_pkg::*;

  localparam int SumW = SampleW + $clog2(TAPS);
  localparam int ProdW = 2 * SumW + 1;
  localparam longint unsigned RecipFull = (64'd1 << SumW) / TAPS;
  localparam logic [SumW:0] RecipMul = (SumW + 1)'(RecipFull);
  localparam int FProdW = FahrXW + Div5MulW;

  logic v2_q, v3_q, v4_q;
  logic [ProdW-1:0] prod_q;
  logic [QuotW-1:0] quot_q;

  logic [QuotW-1:0] quot0;
  logic [SumW-1:0]  quot0_n;
  logic [SumW-1:0]  rem;
  logic [QuotW-1:0] quot_d;

  logic [FahrXW-1:0]         fx;
  logic [FProdW-1:0]         fprod;
  logic signed [FahrW:0]     fahr;
  logic signed [CelsiusW:0]  cels;
  logic signed [16:0]        limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= start_i;
      v3_q <= v2_q;
      v4_q <= v3_q | (v4_q & ~take_i);
    end
  end

  // floor estimate, at most one short
  assign quot0   = prod_q[SumW +: QuotW];
  assign quot0_n = SumW'(quot0) * SumW'(TAPS);
  assign rem     = sum_i - quot0_n;
  assign quot_d  = quot0 + QuotW'(rem >= SumW'(TAPS));

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      prod_q <= ProdW'(sum_i) * ProdW'(RecipMul);
    end
    if (v3_q) begin
      quot_q <= quot_d;
    end
  end

  // F = floor((9q + 4) / 5) - 120372, q = Celsius Q8 + bias
  assign fx    = (FahrXW'(quot_q) << 3) + FahrXW'(quot_q) + FahrRound;
  assign fprod = FProdW'(fx) * FProdW'(Div5Mul);
  assign fahr  = $signed((FahrW + 1)'(fprod[Div5Shift +: FahrW])) - FahrOffset;
  assign cels  = $signed({1'b0, quot_q}) - CelsOffset;
  assign limit = {thr_i, 8'h00};

  assign res_o.mean_c = cels[CelsiusW-1:0];
  assign res_o.mean_f = fahr[FahrW-1:0];
  assign res_o.over   = $signed(cels[CelsiusW-1:0]) > limit;

  assign stat_o.busy       = v2_q | v3_q;
  assign stat_o.last_valid = v4_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> rem < SumW'(2 * TAPS))
    else $error("quotient estimate off by more than one");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({v2_q, v3_q, v4_q}))
    else $error("more than one item in scaler");

endmodule
